// ----- src/rgb_pixel_hsv_component_map_macros.svh -----
// Assertion macros for the RGB pixel HSV component map.
// Included by the modules that carry concurrent assertions; needs no package.
`ifndef RGB_PIXEL_HSV_COMPONENT_MAP_MACROS_SVH
`define RGB_PIXEL_HSV_COMPONENT_MAP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RHSV_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RHSV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/rhsv_pkg.sv -----
// Shared types and codes of the RGB pixel HSV component map.
// No dependencies; used by the interfaces, the divider stage and the top level.
package rhsv_pkg;

	localparam int unsigned CHAN_W = 8;
	localparam int unsigned MODE_W = 3;

	// Mode register codes
	localparam logic [MODE_W-1:0] MODE_ORIG = 3'd0;
	localparam logic [MODE_W-1:0] MODE_NEG  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_HUE  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_SAT  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_VAL  = 3'd4;

	// Hue sector: which channel holds the maximum
	localparam logic [1:0] SECT_RED   = 2'd0;
	localparam logic [1:0] SECT_GREEN = 2'd1;
	localparam logic [1:0] SECT_BLUE  = 2'd2;

	localparam int unsigned HUE_FULL    = 240;
	localparam int unsigned HUE_OFS_GRN = 80;
	localparam int unsigned HUE_OFS_BLU = 160;

	// Quotient bits resolved by one divider stage
	localparam int unsigned DIV_STEPS = 2;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
		logic [CHAN_W-1:0] mx;
		logic [1:0]        sector;
		logic              neg;   // hue difference was negative
		logic              zero;  // divisor is zero, force level to 0
		logic [CHAN_W-1:0] rem;   // partial remainder
		logic [CHAN_W-1:0] low;   // numerator bits still to shift in
		logic [CHAN_W-1:0] quot;  // quotient bits so far
		logic [CHAN_W-1:0] den;   // divisor
	} pipe_t;

endpackage

// ----- src/rhsv_in_if.sv -----
// Input pixel channel: valid/ready handshake with red, green, blue payload.
// Depends on rhsv_pkg for the channel width.
interface rhsv_in_if;
	import rhsv_pkg::*;

	logic              valid;
	logic              ready;
	logic [CHAN_W-1:0] red;
	logic [CHAN_W-1:0] green;
	logic [CHAN_W-1:0] blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// ----- src/rhsv_out_if.sv -----
// Result channel: valid/ready handshake with three output channel bytes.
// Depends on rhsv_pkg for the channel width.
interface rhsv_out_if;
	import rhsv_pkg::*;

	logic              valid;
	logic              ready;
	logic [CHAN_W-1:0] out_red;
	logic [CHAN_W-1:0] out_green;
	logic [CHAN_W-1:0] out_blue;

	modport source (output valid, output out_red, output out_green, output out_blue,
		input ready);
	modport sink   (input valid, input out_red, input out_green, input out_blue,
		output ready);
endinterface

// ----- src/rgb_pixel_hsv_component_map.sv -----
// RGB pixel to HSV component map: six-stage pipeline, one pixel per cycle unless the result is stalled.
// An accepted request passes stage registers 1 to 6 in order; result valid is the stage 6 valid bit.
// Throughput: one request per cycle while result.ready is high; the divider is four pipelined stages
// of two quotient bits each, so every stage takes a new pixel each cycle when not stalled.
// Reset clears every stage valid bit and sets mode to original.
// Depends on rhsv_pkg, rhsv_in_if, rhsv_out_if, rhsv_div_stage and the macros.
`include "rgb_pixel_hsv_component_map_macros.svh"

module rgb_pixel_hsv_component_map (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [rhsv_pkg::MODE_W-1:0] cfg_wdata,
	rhsv_in_if.sink                 pixel,
	rhsv_out_if.source              result
);
	import rhsv_pkg::*;

	// ---------------------------------------------------------------
	// Mode register
	// ---------------------------------------------------------------
	logic [MODE_W-1:0] mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_ORIG;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
		end
	end

	// ---------------------------------------------------------------
	// Stage handshake: a stage takes a request when empty or when the
	// next stage takes its current one, so bubbles collapse.
	// ---------------------------------------------------------------
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_s6;

	assign rdy_s6 = !vld_s6 || result.ready;
	assign rdy_s5 = !vld_s5 || rdy_s6;
	assign rdy_s4 = !vld_s4 || rdy_s5;
	assign rdy_s3 = !vld_s3 || rdy_s4;
	assign rdy_s2 = !vld_s2 || rdy_s3;
	assign rdy_s1 = !vld_s1 || rdy_s2;

	assign pixel.ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= pixel.valid;
			if (rdy_s2) vld_s2 <= vld_s1;
			if (rdy_s3) vld_s3 <= vld_s2;
			if (rdy_s4) vld_s4 <= vld_s3;
			if (rdy_s5) vld_s5 <= vld_s4;
			if (rdy_s6) vld_s6 <= vld_s5;
		end
	end

	// ---------------------------------------------------------------
	// Stage 1: max, min, sector, hue difference and scaled numerator.
	// Both divisions have a quotient below 256, so the top numerator
	// byte seeds the remainder and eight steps remain.
	// ---------------------------------------------------------------
	logic [CHAN_W-1:0]   mx_w, mn_w, d_w, x_w, y_w, abs_w;
	logic [1:0]          sect_w;
	logic [CHAN_W:0]     hdiff_w, hneg_w;
	logic [2*CHAN_W-1:0] hnum_w, snum_w, num_w;
	pipe_t               p1_w;
	pipe_t               pipe_s1, pipe_s2, pipe_s3, pipe_s4, pipe_s5;
	pipe_t               div2_w, div3_w, div4_w, div5_w;

	always_comb begin
		mx_w = pixel.red;
		if (pixel.green > mx_w) mx_w = pixel.green;
		if (pixel.blue > mx_w)  mx_w = pixel.blue;
		mn_w = pixel.red;
		if (pixel.green < mn_w) mn_w = pixel.green;
		if (pixel.blue < mn_w)  mn_w = pixel.blue;
		d_w = mx_w - mn_w;

		// red wins ties, then green
		if (mx_w == pixel.red) begin
			sect_w = SECT_RED;
			x_w    = pixel.green;
			y_w    = pixel.blue;
		end else if (mx_w == pixel.green) begin
			sect_w = SECT_GREEN;
			x_w    = pixel.blue;
			y_w    = pixel.red;
		end else begin
			sect_w = SECT_BLUE;
			x_w    = pixel.red;
			y_w    = pixel.green;
		end

		hdiff_w = {1'b0, x_w} - {1'b0, y_w};
		hneg_w  = '0 - hdiff_w;
		abs_w   = hdiff_w[CHAN_W] ? hneg_w[CHAN_W-1:0] : hdiff_w[CHAN_W-1:0];

		// 40*abs and 240*d by shifts with add and subtract
		hnum_w = ({8'd0, abs_w} << 5) + ({8'd0, abs_w} << 3);
		snum_w = ({8'd0, d_w} << 8) - ({8'd0, d_w} << 4);

		p1_w        = '0;
		p1_w.mode   = mode_q;
		p1_w.red    = pixel.red;
		p1_w.green  = pixel.green;
		p1_w.blue   = pixel.blue;
		p1_w.mx     = mx_w;
		p1_w.sector = sect_w;
		p1_w.neg    = hdiff_w[CHAN_W];
		if (mode_q == MODE_HUE) begin
			num_w       = hnum_w;
			p1_w.den    = d_w;
			p1_w.zero   = (d_w == '0);
		end else begin
			num_w       = snum_w;
			p1_w.den    = mx_w;
			p1_w.zero   = (mx_w == '0);
		end
		p1_w.rem  = num_w[2*CHAN_W-1:CHAN_W];
		p1_w.low  = num_w[CHAN_W-1:0];
		p1_w.quot = '0;
	end

	// ---------------------------------------------------------------
	// Stages 2..5: divider slices
	// ---------------------------------------------------------------
	rhsv_div_stage u_div2 (.din(pipe_s1), .dout(div2_w));
	rhsv_div_stage u_div3 (.din(pipe_s2), .dout(div3_w));
	rhsv_div_stage u_div4 (.din(pipe_s3), .dout(div4_w));
	rhsv_div_stage u_div5 (.din(pipe_s4), .dout(div5_w));

	// payload advances only with a valid request; no reset needed
	always_ff @(posedge clk) begin
		if (rdy_s1 && pixel.valid) pipe_s1 <= p1_w;
		if (rdy_s2 && vld_s1)      pipe_s2 <= div2_w;
		if (rdy_s3 && vld_s2)      pipe_s3 <= div3_w;
		if (rdy_s4 && vld_s3)      pipe_s4 <= div4_w;
		if (rdy_s5 && vld_s4)      pipe_s5 <= div5_w;
	end

	// ---------------------------------------------------------------
	// Stage 6: floor correction, sector offset, wrap, mode select.
	// A negative hue ratio rounds toward minus infinity: bump the
	// magnitude when the remainder is nonzero, then negate.
	// ---------------------------------------------------------------
	logic [CHAN_W:0]     qe_w;
	logic signed [9:0]   hsig_w, hofs_w, hsum_w;
	logic [CHAN_W-1:0]   hue_w, sat_w, lvl_w;
	logic [CHAN_W-1:0]   o_red_w, o_green_w, o_blue_w;
	logic [CHAN_W-1:0]   mode_pad_w;
	logic [CHAN_W-1:0]   out_red_s6, out_green_s6, out_blue_s6;
	logic [MODE_W-1:0]   mode_s6;

	always_comb begin
		qe_w   = {1'b0, pipe_s5.quot} + {8'd0, (pipe_s5.neg && (pipe_s5.rem != '0))};
		hsig_w = pipe_s5.neg ? -$signed({1'b0, qe_w}) : $signed({1'b0, qe_w});
		case (pipe_s5.sector)
			SECT_GREEN: hofs_w = 10'(HUE_OFS_GRN);
			SECT_BLUE:  hofs_w = 10'(HUE_OFS_BLU);
			default:    hofs_w = '0;
		endcase
		hsum_w = hsig_w + hofs_w;
		if (hsum_w < 0) hsum_w = hsum_w + 10'(HUE_FULL);

		hue_w = pipe_s5.zero ? '0 : hsum_w[CHAN_W-1:0];
		sat_w = pipe_s5.zero ? '0 : pipe_s5.quot;

		lvl_w      = '0;
		mode_pad_w = {{(CHAN_W-MODE_W){1'b0}}, pipe_s5.mode};
		o_red_w    = '0;
		o_green_w  = '0;
		o_blue_w   = '0;
		case (pipe_s5.mode)
			MODE_ORIG: begin
				o_red_w   = pipe_s5.red;
				o_green_w = pipe_s5.green;
				o_blue_w  = pipe_s5.blue;
			end
			MODE_NEG: begin
				o_red_w   = ~pipe_s5.red;
				o_green_w = ~pipe_s5.green;
				o_blue_w  = ~pipe_s5.blue;
			end
			MODE_HUE: lvl_w = hue_w;
			MODE_SAT: lvl_w = sat_w;
			MODE_VAL: lvl_w = pipe_s5.mx;
			default:  lvl_w = '0;
		endcase
		// grey modes put one level on all three channels
		if (mode_pad_w >= {{(CHAN_W-MODE_W){1'b0}}, MODE_HUE}) begin
			o_red_w   = lvl_w;
			o_green_w = lvl_w;
			o_blue_w  = lvl_w;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s6 && vld_s5) begin
			out_red_s6   <= o_red_w;
			out_green_s6 <= o_green_w;
			out_blue_s6  <= o_blue_w;
			mode_s6      <= pipe_s5.mode;
		end
	end

	assign result.valid     = vld_s6;
	assign result.out_red   = out_red_s6;
	assign result.out_green = out_green_s6;
	assign result.out_blue  = out_blue_s6;

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	`RHSV_ASSERT_NEXT(a_accept_fills_s1, clk, arst_n, pixel.valid && pixel.ready, vld_s1, "accepted request did not reach stage 1")
	`RHSV_ASSERT_NEXT(a_stall_keeps_result, clk, arst_n, vld_s6 && !result.ready, vld_s6, "stalled result was dropped")
	`RHSV_ASSERT_NOW(a_grey_channels_equal, clk, arst_n, vld_s6 && (mode_s6 == MODE_HUE || mode_s6 == MODE_SAT || mode_s6 == MODE_VAL), (out_red_s6 == out_green_s6) && (out_red_s6 == out_blue_s6), "grey mode channels differ")
	`RHSV_ASSERT_NOW(a_hue_in_range, clk, arst_n, vld_s6 && (mode_s6 == MODE_HUE), out_red_s6 < 8'(HUE_FULL), "hue level out of range")

endmodule

// ----- src/rhsv_div_stage.sv -----
// One slice of the restoring divider: resolves DIV_STEPS quotient bits.
// Depends on rhsv_pkg (pipe_t); registered by the top level.
module rhsv_div_stage (
	input  rhsv_pkg::pipe_t din,
	output rhsv_pkg::pipe_t dout
);
	import rhsv_pkg::*;

	logic [CHAN_W:0]   trial;
	logic [CHAN_W:0]   diff;
	logic [CHAN_W-1:0] rem;
	logic [CHAN_W-1:0] low;
	logic [CHAN_W-1:0] quot;

	always_comb begin
		dout  = din;
		rem   = din.rem;
		low   = din.low;
		quot  = din.quot;
		trial = '0;
		diff  = '0;
		for (int i = 0; i < DIV_STEPS; i++) begin
			// shift in the next numerator bit, subtract when it fits
			trial = {rem, low[CHAN_W-1]};
			low   = {low[CHAN_W-2:0], 1'b0};
			diff  = trial - {1'b0, din.den};
			if (trial >= {1'b0, din.den}) begin
				rem  = diff[CHAN_W-1:0];
				quot = {quot[CHAN_W-2:0], 1'b1};
			end else begin
				rem  = trial[CHAN_W-1:0];
				quot = {quot[CHAN_W-2:0], 1'b0};
			end
		end
		dout.rem  = rem;
		dout.low  = low;
		dout.quot = quot;
	end

endmodule
